[src/gdu_pkg.sv]
// Package for the Gregorian date unit: field widths, stage payload types,
// calendar tables and the constant-divide helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gdu_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 22;
    localparam int Q100_W  = 8;   // 16383 / 100 fits in 8 bits

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

    // Division by 100 as a multiply by a reciprocal: (y * 5243) >> 19 is
    // exact for every 14-bit y.
    localparam int              DIV100_SHIFT = 19;
    localparam logic [12:0]     DIV100_MUL   = 13'd5243;
    localparam logic [6:0]      HUNDRED      = 7'd100;
    localparam logic [8:0]      DAYS_YEAR    = 9'd365;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    // After stage 1: quotients by 100 of the year and the year before.
    typedef struct packed {
        t_date              date;
        logic [YEAR_W-1:0]  py;
        logic [Q100_W-1:0]  q_y;
        logic [Q100_W-1:0]  q_py;
    } t_s1;

    // After stage 2: leap flag, month length, date check, py * 365.
    typedef struct packed {
        t_date              date;
        logic [YEAR_W-1:0]  py;
        logic [Q100_W-1:0]  q_py;
        logic [DN_W-1:0]    base;
        logic               leap;
        logic [DAY_W-1:0]   len;
        logic               ok;
    } t_s2;

    typedef struct packed {
        logic               valid_res;
        logic [YEAR_W-1:0]  next_year;
        logic [MONTH_W-1:0] next_month;
        logic [DAY_W-1:0]   next_dom;
        logic [DN_W-1:0]    day_number;
    } t_res;

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[src/gdu_in_if.sv]
// Request channel of the Gregorian date unit: valid, ready and one date.
// Depends on gdu_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface gdu_in_if;
    import gdu_pkg::*;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;

    modport source (output valid, year, month, day, input ready);
    modport sink   (input valid, year, month, day, output ready);
endinterface
`default_nettype wire

[src/gdu_out_if.sv]
// Result channel of the Gregorian date unit: valid, ready and one result.
// Depends on gdu_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface gdu_out_if;
    import gdu_pkg::*;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [YEAR_W-1:0]  next_year;
    logic [MONTH_W-1:0] next_month;
    logic [DAY_W-1:0]   next_dom;
    logic [DN_W-1:0]    day_number;

    modport source (output valid, valid_res, next_year, next_month, next_dom, day_number,
                    input ready);
    modport sink   (input valid, valid_res, next_year, next_month, next_dom, day_number,
                    output ready);
endinterface
`default_nettype wire

[src/gdu_div_stage.sv]
// Stage 1: divides the year and the year before it by 100 through
// reciprocal multipliers. Depends on gdu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdu_div_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  gdu_pkg::t_date     i_date,
    output logic               o_valid,
    output gdu_pkg::t_s1       o_data
);
    import gdu_pkg::*;

    logic                     r_valid;
    t_s1                      r_data;
    t_s1                      n_data;
    logic [YEAR_W-1:0]        py;
    logic [YEAR_W+12:0]       prod_y;
    logic [YEAR_W+12:0]       prod_py;

    always_comb begin
        py      = i_date.year - YEAR_W'(1);
        prod_y  = i_date.year * DIV100_MUL;
        prod_py = py * DIV100_MUL;
        n_data.date = i_date;
        n_data.py   = py;
        n_data.q_y  = prod_y[DIV100_SHIFT +: Q100_W];
        n_data.q_py = prod_py[DIV100_SHIFT +: Q100_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

[src/gdu_leap_stage.sv]
// Stage 2: leap-year rule, month length, date check and (year - 1) * 365.
// Depends on gdu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdu_leap_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  gdu_pkg::t_s1       i_data,
    output logic               o_valid,
    output gdu_pkg::t_s2       o_data
);
    import gdu_pkg::*;

    logic                  r_valid;
    t_s2                   r_data;
    t_s2                   n_data;
    logic [YEAR_W-1:0]     hundreds;
    logic                  cent;
    logic                  leap;
    logic [DAY_W-1:0]      len;
    logic [YEAR_W+8:0]     base_full;

    always_comb begin
        hundreds  = YEAR_W'(i_data.q_y) * YEAR_W'(HUNDRED);
        cent      = (hundreds == i_data.date.year);
        // Century years are leap only when the quotient by 100 is a multiple of 4.
        leap      = cent ? (i_data.q_y[1:0] == 2'b00) : (i_data.date.year[1:0] == 2'b00);
        len       = month_length(i_data.date.month, leap);
        base_full = i_data.py * DAYS_YEAR;
        n_data.date = i_data.date;
        n_data.py   = i_data.py;
        n_data.q_py = i_data.q_py;
        n_data.base = base_full[DN_W-1:0];
        n_data.leap = leap;
        n_data.len  = len;
        n_data.ok   = (i_data.date.year != '0) && (i_data.date.year <= YEAR_MAX)
                   && (i_data.date.month >= MONTH_JAN) && (i_data.date.month <= MONTH_DEC)
                   && (i_data.date.day >= DAY_FIRST) && (i_data.date.day <= len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

[src/gdu_out_stage.sv]
// Stage 3: day-number sum and successor date, held in the output register.
// Depends on gdu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gdu_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  gdu_pkg::t_s2       i_data,
    output logic               o_valid,
    output gdu_pkg::t_res      o_res
);
    import gdu_pkg::*;

    logic               r_valid;
    t_res               r_res;
    t_res               n_res;
    logic [DN_W:0]      dn_sum;
    logic [YEAR_W-1:0]  ny;
    logic [MONTH_W-1:0] nm;
    logic [DAY_W-1:0]   nd;

    always_comb begin
        ny = i_data.date.year;
        nm = i_data.date.month;
        nd = i_data.date.day + DAY_W'(1);
        if (i_data.date.day == i_data.len) begin
            nd = DAY_FIRST;
            if (i_data.date.month == MONTH_DEC) begin
                nm = MONTH_JAN;
                ny = i_data.date.year + YEAR_W'(1);
            end else begin
                nm = i_data.date.month + MONTH_W'(1);
            end
        end

        dn_sum = (DN_W+1)'(i_data.base)
               + (DN_W+1)'(i_data.py >> 2)
               - (DN_W+1)'(i_data.q_py)
               + (DN_W+1)'(i_data.q_py >> 2)
               + (DN_W+1)'(days_before(i_data.date.month))
               + (DN_W+1)'(i_data.date.day)
               + (DN_W+1)'(i_data.leap && (i_data.date.month > MONTH_FEB));

        if (i_data.ok) begin
            n_res.valid_res  = 1'b1;
            n_res.next_year  = ny;
            n_res.next_month = nm;
            n_res.next_dom   = nd;
            n_res.day_number = dn_sum[DN_W-1:0];
        end else begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

[src/gregorian_date_unit_core.sv]
// Gregorian date unit: date check, next date and day number from 0001-01-01.
// A request passes through the division, leap and output stage registers on its way to o_res.
// Throughput: one request per cycle while o_res is ready; a stage moves whenever the stage after it is empty or moves.
// Reset: synchronous, active low; empties all three stages, no other state.
// Depends on gdu_pkg, gdu_in_if, gdu_out_if and the three stage modules.
`timescale 1ns / 1ps
`default_nettype none
module gregorian_date_unit_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gdu_in_if.sink     i_req,
    gdu_out_if.source  o_res
);
    import gdu_pkg::*;

    t_date  in_date;
    t_s1    s1_data;
    t_s2    s2_data;
    t_res   s3_res;
    logic   s1_valid;
    logic   s2_valid;
    logic   s3_valid;
    logic   adv1;
    logic   adv2;
    logic   adv3;

    // Each stage advances when its slot is empty or the next stage advances.
    assign adv3 = !s3_valid || o_res.ready;
    assign adv2 = !s2_valid || adv3;
    assign adv1 = !s1_valid || adv2;

    assign i_req.ready   = adv1;
    assign in_date.year  = i_req.year;
    assign in_date.month = i_req.month;
    assign in_date.day   = i_req.day;

    gdu_div_stage u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv1),
        .i_valid (i_req.valid),
        .i_date  (in_date),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    gdu_leap_stage u_leap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    gdu_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_valid (s3_valid),
        .o_res   (s3_res)
    );

    assign o_res.valid      = s3_valid;
    assign o_res.valid_res  = s3_res.valid_res;
    assign o_res.next_year  = s3_res.next_year;
    assign o_res.next_month = s3_res.next_month;
    assign o_res.next_dom   = s3_res.next_dom;
    assign o_res.day_number = s3_res.day_number;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.valid_res) |->
        (o_res.next_year == '0 && o_res.next_month == '0 && o_res.next_dom == '0
         && o_res.day_number == '0))
        else $error("invalid date result carries nonzero fields");

    a_next_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.valid_res) |->
        (o_res.next_month >= MONTH_JAN && o_res.next_month <= MONTH_DEC
         && o_res.next_dom >= DAY_FIRST && o_res.day_number != '0))
        else $error("valid result out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (s1_valid && s2_valid && s3_valid && !o_res.ready))
        else $error("request stalled with a free pipeline slot");

    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_res.valid)
        else $error("result valid right after reset");
`endif
endmodule
`default_nettype wire

[bench/tb_gregorian_date_unit_core.sv]
// Testbench for gregorian_date_unit_core: date requests go in on one channel, and each
// result is checked against a calendar predictor kept inside the bench.
// Depends on gdu_pkg, gdu_in_if, gdu_out_if and the core with its stage modules.
`timescale 1ns / 1ps
module tb_gregorian_date_unit_core;
    import gdu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 23;

    typedef struct {
        t_date src;
        t_res  want;
    } t_date_check;

    logic i_clk;
    logic i_rst_n;

    gdu_in_if  req_if();
    gdu_out_if res_if();

    gregorian_date_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_date_check pending_dates[$];
    int          err_count;
    int          n_requests;
    int          n_results;
    int          n_valid_dates;
    int          n_year_rollovers;
    int          cycle_count;
    bit          stalls_enabled;

    t_date_check head;
    t_res        got;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit leap_year(int y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int month_days(int y, int m);
        int n;
        case (m)
            2:             n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Validity, following date and day count for one date; all zero when it does not exist.
    function automatic t_res predict_following_date(t_date dt);
        t_res r;
        int   y;
        int   m;
        int   d;
        int   len;
        int   py;
        int   dn;
        r = '0;
        y = dt.year;
        m = dt.month;
        d = dt.day;
        if (y < 1 || y > YEAR_MAX || m < 1 || m > 12 || d < 1)
            return r;
        len = month_days(y, m);
        if (d > len)
            return r;
        r.valid_res  = 1'b1;
        r.next_year  = YEAR_W'(y);
        r.next_month = MONTH_W'(m);
        r.next_dom   = DAY_W'(d + 1);
        if (d == len) begin
            r.next_dom = DAY_FIRST;
            if (m == 12) begin
                r.next_month = MONTH_JAN;
                r.next_year  = YEAR_W'(y + 1);
            end else begin
                r.next_month = MONTH_W'(m + 1);
            end
        end
        py = y - 1;
        dn = py * 365 + py / 4 - py / 100 + py / 400 + d;
        for (int k = 1; k < m; k++)
            dn += month_days(y, k);
        r.day_number = DN_W'(dn);
        return r;
    endfunction

    task automatic report_mismatch(string field, t_date src, int unsigned seen, int unsigned want);
        $display("MISMATCH %s for %0d-%0d-%0d: got %0d, expected %0d",
                 field, src.year, src.month, src.day, seen, want);
        err_count++;
    endtask

    // Accepted requests are predicted here; accepted results are compared in order.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            head.src.year  = req_if.year;
            head.src.month = req_if.month;
            head.src.day   = req_if.day;
            head.want      = predict_following_date(head.src);
            pending_dates.push_back(head);
            n_requests++;
            if (head.want.valid_res) begin
                n_valid_dates++;
                if (head.want.next_year != head.src.year)
                    n_year_rollovers++;
            end
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_results++;
            got.valid_res  = res_if.valid_res;
            got.next_year  = res_if.next_year;
            got.next_month = res_if.next_month;
            got.next_dom   = res_if.next_dom;
            got.day_number = res_if.day_number;
            if (pending_dates.size() == 0) begin
                $display("UNEXPECTED result: valid_res %0d next %0d-%0d-%0d day_number %0d",
                         got.valid_res, got.next_year, got.next_month, got.next_dom,
                         got.day_number);
                err_count++;
            end else begin
                head = pending_dates.pop_front();
                if (got.valid_res !== head.want.valid_res)
                    report_mismatch("valid_res", head.src, got.valid_res, head.want.valid_res);
                if (got.next_year !== head.want.next_year)
                    report_mismatch("next_year", head.src, got.next_year, head.want.next_year);
                if (got.next_month !== head.want.next_month)
                    report_mismatch("next_month", head.src, got.next_month, head.want.next_month);
                if (got.next_dom !== head.want.next_dom)
                    report_mismatch("next_dom", head.src, got.next_dom, head.want.next_dom);
                if (got.day_number !== head.want.day_number)
                    report_mismatch("day_number", head.src, got.day_number, head.want.day_number);
            end
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        if (i_rst_n)
            res_if.ready <= !stalls_enabled || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TIMEOUT after %0d cycles, %0d results still pending",
                 cycle_count, pending_dates.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Present one request and hold it until the core takes it.
    task automatic send_date(int y, int m, int d);
        @(negedge i_clk);
        if (stalls_enabled) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_if.valid = 1'b0;
                @(negedge i_clk);
            end
        end
        req_if.valid = 1'b1;
        req_if.year  = YEAR_W'(y);
        req_if.month = MONTH_W'(m);
        req_if.day   = DAY_W'(d);
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_dates.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_calendar_edges();
        send_date(1, 1, 1);
        send_date(9999, 12, 31);
        send_date(9999, 1, 1);
        send_date(0, 6, 15);
        send_date(16383, 15, 31);
        send_date(10000, 1, 1);
        send_date(2021, 0, 10);
        send_date(2021, 13, 10);
        send_date(2021, 15, 1);
        send_date(2021, 7, 0);
        send_date(2021, 4, 31);
        send_date(2021, 1, 31);
        send_date(2021, 12, 31);
        send_date(1999, 4, 30);
    endtask

    task automatic test_leap_rule();
        send_date(2000, 2, 29);
        send_date(1900, 2, 29);
        send_date(2024, 2, 29);
        send_date(2023, 2, 29);
        send_date(2023, 2, 28);
        send_date(2024, 2, 28);
        send_date(2024, 2, 30);
        send_date(2000, 3, 1);
        send_date(1900, 3, 1);
    endtask

    // Mostly existing dates, weighted toward month ends and century years, with
    // some near misses and some fully random fields.
    task automatic test_random_dates(int count);
        int y;
        int m;
        int d;
        int len;
        int pick;
        for (int i = 0; i < count; i++) begin
            y = $urandom_range(9999, 1);
            if ($urandom_range(9) == 0)
                y = $urandom_range(99, 1) * 100;
            m = $urandom_range(12, 1);
            len = month_days(y, m);
            pick = $urandom_range(99);
            if (pick < 70) begin
                case ($urandom_range(3))
                    0, 1:    d = $urandom_range(len, 1);
                    2:       d = len;
                    default: d = 1;
                endcase
            end else if (pick < 85) begin
                d = $urandom_range(len, 1);
                case ($urandom_range(5))
                    0:       d = len + 1;
                    1:       y = 0;
                    2:       y = $urandom_range(16383, 10000);
                    3:       m = $urandom_range(15, 13);
                    4:       d = 0;
                    default: begin
                        y = 9999;
                        m = 12;
                        d = $urandom_range(31, 30);
                    end
                endcase
            end else begin
                y = $urandom_range(16383);
                m = $urandom_range(15);
                d = $urandom_range(31);
            end
            send_date(y, m, d);
        end
    endtask

    task automatic test_burst_then_drain();
        test_random_dates(30);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        stalls_enabled = 1'b0;
        test_random_dates(200);
        stalls_enabled = 1'b1;
    endtask

    initial begin
        err_count        = 0;
        n_requests       = 0;
        n_results        = 0;
        n_valid_dates    = 0;
        n_year_rollovers = 0;
        stalls_enabled   = 1'b1;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.year      = '0;
        req_if.month     = '0;
        req_if.day       = '0;
        res_if.ready     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_calendar_edges();
        test_leap_rule();
        test_random_dates(400);
        test_burst_then_drain();
        test_back_to_back();
        test_random_dates(200);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d dates (%0d existing, %0d crossing into a new year), %0d results",
                 n_requests, n_valid_dates, n_year_rollovers, n_results);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
